### hw/rtl/cvr_pkg.sv
// Package for the camera vector rotator: fixed-point constants, the CORDIC
// arctangent table and the request/status structs between the sequencer and
// the CORDIC unit. No dependencies.
`default_nettype none

package cvr_pkg;

    localparam int VEC_WIDTH_DEFAULT  = 16;
    localparam int CORDIC_ITER_DEFAULT = 16;

    localparam int ANG_W      = 16;  // binary angle, 65536 units per turn
    localparam int RATE_W     = 16;  // base rate and turn offset, Q4.12
    localparam int FT_W       = 16;  // frame time, Q0.16
    localparam int GUARD_BITS = 16;
    localparam int Z_W        = 34;  // angle residual with headroom
    localparam int ATAN_DEPTH = 30;
    localparam int ATAN_IDX_W = 5;

    localparam logic [RATE_W-1:0] BASE_RATE_RESET = 16'd512;

    // Limit gain 0.60725293500888 in Q1.30.
    localparam logic signed [31:0] GAIN_Q30 = 32'sd652032874;

    localparam logic signed [Z_W-1:0] QUARTER_TURN = 34'sd1073741824;
    localparam logic signed [Z_W-1:0] HALF_TURN    = 34'sd2147483648;

    // atan(2^-i) in 32-bit binary angle units.
    localparam logic [31:0] ATAN_TABLE [ATAN_DEPTH] = '{
        32'd536870912, 32'd316933406, 32'd167458907, 32'd85004756,
        32'd42667331,  32'd21354465,  32'd10680862,  32'd5340245,
        32'd2670163,   32'd1335087,   32'd667544,    32'd333772,
        32'd166886,    32'd83443,     32'd41722,     32'd20861,
        32'd10430,     32'd5215,      32'd2608,      32'd1304,
        32'd652,       32'd326,       32'd163,       32'd81,
        32'd41,        32'd20,        32'd10,        32'd5,
        32'd3,         32'd1
    };

    typedef struct packed {
        logic             start;
        logic [ANG_W-1:0] angle;
    } cvr_req_t;

    typedef struct packed {
        logic busy;
        logic done;
    } cvr_sts_t;

endpackage

`default_nettype wire

### hw/rtl/cvr_if.sv
// Valid/ready channel interfaces for the camera vector rotator: the input
// item channel and the result channel. No dependencies.
`default_nettype none

interface cvr_in_if #(
    parameter int VEC_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic                        func;
    logic [15:0]                 frame_period;
    logic [15:0]                 turn_offset;
    logic                        turn_left;
    logic                        turn_right;
    logic signed [VEC_WIDTH-1:0] load_dir_x;
    logic signed [VEC_WIDTH-1:0] load_dir_y;
    logic signed [VEC_WIDTH-1:0] load_plane_x;
    logic signed [VEC_WIDTH-1:0] load_plane_y;

    modport source (
        output valid, func, frame_period, turn_offset, turn_left, turn_right,
               load_dir_x, load_dir_y, load_plane_x, load_plane_y,
        input  ready
    );

    modport sink (
        input  valid, func, frame_period, turn_offset, turn_left, turn_right,
               load_dir_x, load_dir_y, load_plane_x, load_plane_y,
        output ready
    );
endinterface

interface cvr_out_if #(
    parameter int VEC_WIDTH = 16
);
    logic                        valid;
    logic                        ready;
    logic signed [VEC_WIDTH-1:0] dir_x;
    logic signed [VEC_WIDTH-1:0] dir_y;
    logic signed [VEC_WIDTH-1:0] plane_x;
    logic signed [VEC_WIDTH-1:0] plane_y;

    modport source (
        output valid, dir_x, dir_y, plane_x, plane_y,
        input  ready
    );

    modport sink (
        input  valid, dir_x, dir_y, plane_x, plane_y,
        output ready
    );
endinterface

`default_nettype wire

### hw/rtl/cvr_cordic.sv
// Iterative CORDIC rotation unit with gain correction, rounding and
// saturation. One micro-rotation per cycle. Depends on cvr_pkg.
`default_nettype none

module cvr_cordic #(
    parameter int VEC_WIDTH   = cvr_pkg::VEC_WIDTH_DEFAULT,
    parameter int CORDIC_ITER = cvr_pkg::CORDIC_ITER_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire cvr_pkg::cvr_req_t           req,
    output cvr_pkg::cvr_sts_t                sts,
    input  wire logic signed [VEC_WIDTH-1:0] x_in,
    input  wire logic signed [VEC_WIDTH-1:0] y_in,
    output logic signed [VEC_WIDTH-1:0]      x_out,
    output logic signed [VEC_WIDTH-1:0]      y_out
);
    import cvr_pkg::*;

    localparam int XW = VEC_WIDTH + GUARD_BITS + 4;
    localparam int RW = XW - GUARD_BITS;
    localparam int PW = VEC_WIDTH + 32;
    localparam int CW = $clog2(CORDIC_ITER);
    localparam logic [CW-1:0] ITER_LAST = CW'(CORDIC_ITER - 1);
    localparam logic signed [XW-1:0] ROUND_HALF = XW'(longint'(1) << (GUARD_BITS - 1));
    localparam logic signed [RW-1:0] SAT_HI = RW'((longint'(1) << (VEC_WIDTH - 1)) - 1);
    localparam logic signed [RW-1:0] SAT_LO = -SAT_HI - RW'(1);

    typedef enum logic [5:0] {
        C_IDLE   = 6'b000001,
        C_GAIN_X = 6'b000010,
        C_GAIN_Y = 6'b000100,
        C_FOLD   = 6'b001000,
        C_ITER   = 6'b010000,
        C_ROUND  = 6'b100000
    } cstate_t;

    cstate_t                state_reg, state_next;
    logic [CW-1:0]          iter_reg, iter_next;
    logic signed [XW-1:0]   x_reg, x_next, y_reg, y_next;
    logic signed [Z_W-1:0]  z_reg, z_next;

    logic signed [VEC_WIDTH-1:0] mul_a;
    logic signed [PW-1:0]        prod;
    logic signed [XW-1:0]        gained;
    logic signed [XW-1:0]        dx, dy;
    logic signed [Z_W-1:0]       atan_z;
    logic signed [RW-1:0]        x_rnd, y_rnd;

    // The one multiplier serves both components, x first and then y.
    assign mul_a  = (state_reg == C_GAIN_X) ? x_in : y_in;
    assign prod   = mul_a * GAIN_Q30;
    assign gained = XW'(prod >>> (30 - GUARD_BITS));

    assign dx     = y_reg >>> iter_reg;
    assign dy     = x_reg >>> iter_reg;
    assign atan_z = Z_W'(ATAN_TABLE[ATAN_IDX_W'(iter_reg)]);

    always_comb
    begin
        state_next = state_reg;
        iter_next  = iter_reg;
        x_next     = x_reg;
        y_next     = y_reg;
        z_next     = z_reg;
        unique case (state_reg)
            C_IDLE:
            begin
                if (req.start)
                begin
                    z_next     = Z_W'($signed({req.angle, 16'h0000}));
                    state_next = C_GAIN_X;
                end
            end
            C_GAIN_X:
            begin
                x_next     = gained;
                state_next = C_GAIN_Y;
            end
            C_GAIN_Y:
            begin
                y_next     = gained;
                state_next = C_FOLD;
            end
            C_FOLD:
            begin
                // Beyond a quarter turn the vector is negated and the angle
                // moved by a half turn, so CORDIC converges.
                if (z_reg > QUARTER_TURN)
                begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                    z_next = z_reg - HALF_TURN;
                end
                else if (z_reg < -QUARTER_TURN)
                begin
                    x_next = -x_reg;
                    y_next = -y_reg;
                    z_next = z_reg + HALF_TURN;
                end
                iter_next  = '0;
                state_next = C_ITER;
            end
            C_ITER:
            begin
                if (!z_reg[Z_W-1])
                begin
                    x_next = x_reg - dx;
                    y_next = y_reg + dy;
                    z_next = z_reg - atan_z;
                end
                else
                begin
                    x_next = x_reg + dx;
                    y_next = y_reg - dy;
                    z_next = z_reg + atan_z;
                end
                iter_next = iter_reg + CW'(1);
                if (iter_reg == ITER_LAST)
                begin
                    state_next = C_ROUND;
                end
            end
            C_ROUND:
            begin
                state_next = C_IDLE;
            end
            default:
            begin
                state_next = C_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= C_IDLE;
            iter_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            iter_reg  <= iter_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        y_reg <= y_next;
        z_reg <= z_next;
    end

    // Round half up while dropping the guard bits, then saturate.
    assign x_rnd = RW'((x_reg + ROUND_HALF) >>> GUARD_BITS);
    assign y_rnd = RW'((y_reg + ROUND_HALF) >>> GUARD_BITS);

    always_comb
    begin
        priority if (x_rnd > SAT_HI)
            x_out = SAT_HI[VEC_WIDTH-1:0];
        else if (x_rnd < SAT_LO)
            x_out = SAT_LO[VEC_WIDTH-1:0];
        else
            x_out = x_rnd[VEC_WIDTH-1:0];
        priority if (y_rnd > SAT_HI)
            y_out = SAT_HI[VEC_WIDTH-1:0];
        else if (y_rnd < SAT_LO)
            y_out = SAT_LO[VEC_WIDTH-1:0];
        else
            y_out = y_rnd[VEC_WIDTH-1:0];
    end

    assign sts.busy = (state_reg != C_IDLE);
    assign sts.done = (state_reg == C_ROUND);

endmodule

`default_nettype wire

### hw/rtl/camera_vector_rotator_top.sv
// Top level of the camera vector rotator: the item sequencer, the vector
// state, the configuration register and the result register.
// Depends on cvr_pkg, cvr_if (cvr_in_if, cvr_out_if) and cvr_cordic.
//
// Usage:
//   in_ch carries one item per transaction. func 0 is a tick that turns the
//   facing and camera plane vectors left and/or right by an angle taken from
//   the frame period and the turn rate; func 1 loads both vectors.
//   out_ch returns the four vector components after every item, one
//   transaction per item.
//   cfg_we/cfg_wdata write base_rate; write only while the block is idle.
// Item flow:
//   in_ch.ready is high only while no item is in work. A load item goes
//   through S_DONE into the result register. A tick computes its angle in
//   S_ANGLE, then runs k = 0, 2 or 4 rotations (two vectors per turn flag)
//   and ends in S_DONE; each rotation runs the single shared CORDIC unit: a
//   start, the gain multiplies of x and then y, a fold, CORDIC_ITER
//   micro-rotations and a rounding step.
// Reset: facing = (-1, 0), plane = (0, 0.66), base_rate = 0.125, no result.
// Stall: a finished result waits in the output register; the block accepts the
//   next item meanwhile, and holds that item's result until the register frees.
`default_nettype none

module camera_vector_rotator_top #(
    parameter int VEC_WIDTH   = cvr_pkg::VEC_WIDTH_DEFAULT,
    parameter int CORDIC_ITER = cvr_pkg::CORDIC_ITER_DEFAULT
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_we,
    input  wire logic [cvr_pkg::RATE_W-1:0]  cfg_wdata,
    cvr_in_if.sink                           in_ch,
    cvr_out_if.source                        out_ch
);
    import cvr_pkg::*;

    localparam logic signed [VEC_WIDTH-1:0] DIR_X_RESET =
        VEC_WIDTH'(-(longint'(1) << (VEC_WIDTH - 2)));
    localparam logic signed [VEC_WIDTH-1:0] PLANE_Y_RESET =
        VEC_WIDTH'((longint'(66) * (longint'(1) << (VEC_WIDTH - 2))) / 100);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_ANGLE = 4'b0010,
        S_ROT   = 4'b0100,
        S_DONE  = 4'b1000
    } state_t;

    // Rotation passes: left on dir, left on plane, right on dir, right on plane.
    localparam logic [1:0] PASS_L_DIR   = 2'd0;
    localparam logic [1:0] PASS_L_PLANE = 2'd1;
    localparam logic [1:0] PASS_R_DIR   = 2'd2;
    localparam logic [1:0] PASS_R_PLANE = 2'd3;

    state_t                      state_reg, state_next;
    logic [1:0]                  pass_reg, pass_next;
    logic                        start_reg, start_next;
    logic                        left_reg, left_next, right_reg, right_next;
    logic [FT_W-1:0]             ft_reg, ft_next;
    logic [RATE_W-1:0]           off_reg, off_next;
    logic [ANG_W-1:0]            angle_reg, angle_next;
    logic [RATE_W-1:0]           base_rate_reg, base_rate_next;
    logic signed [VEC_WIDTH-1:0] dir_x_reg, dir_x_next, dir_y_reg, dir_y_next;
    logic signed [VEC_WIDTH-1:0] plane_x_reg, plane_x_next, plane_y_reg, plane_y_next;
    logic                        out_valid_reg, out_valid_next;
    logic signed [VEC_WIDTH-1:0] out_dx_reg, out_dx_next, out_dy_reg, out_dy_next;
    logic signed [VEC_WIDTH-1:0] out_px_reg, out_px_next, out_py_reg, out_py_next;

    logic                        in_accept;
    logic [RATE_W:0]             rate;
    logic [FT_W+RATE_W:0]        ang_prod;
    logic [FT_W+RATE_W+1:0]      ang_sum;
    cvr_req_t                    cordic_req;
    cvr_sts_t                    cordic_sts;
    logic signed [VEC_WIDTH-1:0] cx_in, cy_in, cx_out, cy_out;

    assign in_ch.ready = (state_reg == S_IDLE);
    assign in_accept   = in_ch.valid && in_ch.ready;

    assign rate     = (RATE_W + 1)'(base_rate_reg) + (RATE_W + 1)'(off_reg);
    assign ang_prod = (FT_W + RATE_W + 1)'(ft_reg) * (FT_W + RATE_W + 1)'(rate);
    assign ang_sum  = (FT_W + RATE_W + 2)'(ang_prod) + (FT_W + RATE_W + 2)'(4096);

    assign cordic_req.start = start_reg;
    assign cordic_req.angle = pass_reg[1] ? ANG_W'(ANG_W'(0) - angle_reg) : angle_reg;
    assign cx_in = pass_reg[0] ? plane_x_reg : dir_x_reg;
    assign cy_in = pass_reg[0] ? plane_y_reg : dir_y_reg;

    cvr_cordic #(
        .VEC_WIDTH   (VEC_WIDTH),
        .CORDIC_ITER (CORDIC_ITER)
    ) u_cordic (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (cordic_req),
        .sts   (cordic_sts),
        .x_in  (cx_in),
        .y_in  (cy_in),
        .x_out (cx_out),
        .y_out (cy_out)
    );

    always_comb
    begin
        state_next     = state_reg;
        pass_next      = pass_reg;
        start_next     = 1'b0;
        left_next      = left_reg;
        right_next     = right_reg;
        ft_next        = ft_reg;
        off_next       = off_reg;
        angle_next     = angle_reg;
        base_rate_next = cfg_we ? cfg_wdata : base_rate_reg;
        dir_x_next     = dir_x_reg;
        dir_y_next     = dir_y_reg;
        plane_x_next   = plane_x_reg;
        plane_y_next   = plane_y_reg;
        out_valid_next = out_valid_reg && !out_ch.ready;
        out_dx_next    = out_dx_reg;
        out_dy_next    = out_dy_reg;
        out_px_next    = out_px_reg;
        out_py_next    = out_py_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept)
                begin
                    if (in_ch.func)
                    begin
                        dir_x_next   = in_ch.load_dir_x;
                        dir_y_next   = in_ch.load_dir_y;
                        plane_x_next = in_ch.load_plane_x;
                        plane_y_next = in_ch.load_plane_y;
                        state_next   = S_DONE;
                    end
                    else
                    begin
                        ft_next    = in_ch.frame_period;
                        off_next   = in_ch.turn_offset;
                        left_next  = in_ch.turn_left;
                        right_next = in_ch.turn_right;
                        state_next = S_ANGLE;
                    end
                end
            end
            S_ANGLE:
            begin
                angle_next = ang_sum[ANG_W+12:13];
                priority if (left_reg)
                begin
                    pass_next  = PASS_L_DIR;
                    start_next = 1'b1;
                    state_next = S_ROT;
                end
                else if (right_reg)
                begin
                    pass_next  = PASS_R_DIR;
                    start_next = 1'b1;
                    state_next = S_ROT;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_ROT:
            begin
                if (cordic_sts.done)
                begin
                    if (pass_reg[0])
                    begin
                        plane_x_next = cx_out;
                        plane_y_next = cy_out;
                    end
                    else
                    begin
                        dir_x_next = cx_out;
                        dir_y_next = cy_out;
                    end
                    unique case (pass_reg)
                        PASS_L_DIR:
                        begin
                            pass_next  = PASS_L_PLANE;
                            start_next = 1'b1;
                        end
                        PASS_L_PLANE:
                        begin
                            if (right_reg)
                            begin
                                pass_next  = PASS_R_DIR;
                                start_next = 1'b1;
                            end
                            else
                            begin
                                state_next = S_DONE;
                            end
                        end
                        PASS_R_DIR:
                        begin
                            pass_next  = PASS_R_PLANE;
                            start_next = 1'b1;
                        end
                        PASS_R_PLANE:
                        begin
                            state_next = S_DONE;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_DONE:
            begin
                // The result register frees when its transaction completes.
                if (!out_valid_reg || out_ch.ready)
                begin
                    out_valid_next = 1'b1;
                    out_dx_next    = dir_x_reg;
                    out_dy_next    = dir_y_reg;
                    out_px_next    = plane_x_reg;
                    out_py_next    = plane_y_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            pass_reg      <= PASS_L_DIR;
            start_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            base_rate_reg <= BASE_RATE_RESET;
            dir_x_reg     <= DIR_X_RESET;
            dir_y_reg     <= '0;
            plane_x_reg   <= '0;
            plane_y_reg   <= PLANE_Y_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            start_reg     <= start_next;
            out_valid_reg <= out_valid_next;
            base_rate_reg <= base_rate_next;
            dir_x_reg     <= dir_x_next;
            dir_y_reg     <= dir_y_next;
            plane_x_reg   <= plane_x_next;
            plane_y_reg   <= plane_y_next;
        end
    end

    always_ff @(posedge clk)
    begin
        left_reg   <= left_next;
        right_reg  <= right_next;
        ft_reg     <= ft_next;
        off_reg    <= off_next;
        angle_reg  <= angle_next;
        out_dx_reg <= out_dx_next;
        out_dy_reg <= out_dy_next;
        out_px_reg <= out_px_next;
        out_py_reg <= out_py_next;
    end

    assign out_ch.valid   = out_valid_reg;
    assign out_ch.dir_x   = out_dx_reg;
    assign out_ch.dir_y   = out_dy_reg;
    assign out_ch.plane_x = out_px_reg;
    assign out_ch.plane_y = out_py_reg;

    // The CORDIC unit only finishes a rotation that the sequencer waits for.
    a_done_in_rot: assert property (@(posedge clk) disable iff (!rst_n)
        cordic_sts.done |-> (state_reg == S_ROT))
        else $error("CORDIC finished outside a rotation pass");

    // A start reaches an idle CORDIC unit and is a single-cycle pulse.
    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start_reg |-> (!cordic_sts.busy && (state_reg == S_ROT)) ##1 !start_reg)
        else $error("CORDIC start while busy or held too long");

    // A load transaction goes straight to the result stage.
    a_load_done: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && in_ch.func) |=> (state_reg == S_DONE))
        else $error("Load item did not go to the result stage");

endmodule

`default_nettype wire

### tb/tb_camera_vector_rotator_top.sv
// Testbench for camera_vector_rotator_top: drives items and base rate writes,
// predicts the rotated facing and camera plane vectors, and checks every result.
// Depends on cvr_pkg, cvr_if (cvr_in_if, cvr_out_if) and the rotator RTL.
`timescale 1ns / 100ps

module tb_camera_vector_rotator_top;

    localparam int VW    = 16;
    localparam int STEPS = 16;
    localparam int GUARD = 16;

    localparam bit FUNC_TICK = 1'b0;
    localparam bit FUNC_LOAD = 1'b1;

    localparam longint GAIN_Q30    = 64'sd652032874;
    localparam longint QTR_TURN    = 64'sd1073741824;
    localparam longint HALF_TURN_L = 64'sd2147483648;
    localparam longint VEC_MAX     = 64'sd32767;
    localparam longint VEC_MIN     = -64'sd32768;

    localparam longint FACE_X_RESET  = -64'sd16384;
    localparam longint PLANE_Y_RESET = 64'sd10813;

    typedef struct {
        bit                 func;
        bit [15:0]          frame_period;
        bit [15:0]          turn_offset;
        bit                 turn_left;
        bit                 turn_right;
        bit signed [VW-1:0] load_dir_x;
        bit signed [VW-1:0] load_dir_y;
        bit signed [VW-1:0] load_plane_x;
        bit signed [VW-1:0] load_plane_y;
    } cam_item_t;

    typedef struct {
        logic signed [VW-1:0] dir_x;
        logic signed [VW-1:0] dir_y;
        logic signed [VW-1:0] plane_x;
        logic signed [VW-1:0] plane_y;
    } cam_vec_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_we;
    logic [cvr_pkg::RATE_W-1:0] cfg_wdata;

    cvr_in_if  #(.VEC_WIDTH(VW)) in_ch ();
    cvr_out_if #(.VEC_WIDTH(VW)) out_ch ();

    camera_vector_rotator_top #(
        .VEC_WIDTH   (VW),
        .CORDIC_ITER (STEPS)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_ch     (in_ch),
        .out_ch    (out_ch)
    );

    // Shadow of the block's vectors and rate register.
    longint    cam_face_x;
    longint    cam_face_y;
    longint    cam_plane_x;
    longint    cam_plane_y;
    bit [15:0] base_rate_shadow;

    cam_vec_t expected_vectors [$];
    int       mismatch_count;
    bit       no_idle;
    int       rx_hold_req;

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // atan(2^-i) in 32-bit binary angle units.
    function automatic longint arctan_unit(input int i);
        case (i)
            0:  return 64'sd536870912;
            1:  return 64'sd316933406;
            2:  return 64'sd167458907;
            3:  return 64'sd85004756;
            4:  return 64'sd42667331;
            5:  return 64'sd21354465;
            6:  return 64'sd10680862;
            7:  return 64'sd5340245;
            8:  return 64'sd2670163;
            9:  return 64'sd1335087;
            10: return 64'sd667544;
            11: return 64'sd333772;
            12: return 64'sd166886;
            13: return 64'sd83443;
            14: return 64'sd41722;
            default: return 64'sd20861;
        endcase
    endfunction

    function automatic longint clamp_q2_14(input longint v);
        if (v > VEC_MAX)
            return VEC_MAX;
        if (v < VEC_MIN)
            return VEC_MIN;
        return v;
    endfunction

    function automatic void turn_vector(inout longint vx, inout longint vy,
                                        input bit [15:0] ang);
        longint x;
        longint y;
        longint z;
        longint dx;
        longint dy;
        x = (vx * GAIN_Q30) >>> (30 - GUARD);
        y = (vy * GAIN_Q30) >>> (30 - GUARD);
        z = longint'($signed(ang)) * 64'sd65536;
        // Angles beyond a quarter turn are folded by negating the vector.
        if (z > QTR_TURN)
        begin
            x = -x;
            y = -y;
            z = z - HALF_TURN_L;
        end
        else if (z < -QTR_TURN)
        begin
            x = -x;
            y = -y;
            z = z + HALF_TURN_L;
        end
        for (int i = 0; i < STEPS; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0)
            begin
                x = x - dx;
                y = y + dy;
                z = z - arctan_unit(i);
            end
            else
            begin
                x = x + dx;
                y = y - dy;
                z = z + arctan_unit(i);
            end
        end
        vx = clamp_q2_14((x + 64'sd32768) >>> GUARD);
        vy = clamp_q2_14((y + 64'sd32768) >>> GUARD);
    endfunction

    function automatic cam_vec_t predict_vectors(input cam_item_t it);
        cam_vec_t  res;
        longint    prod;
        bit [15:0] ang;
        bit [15:0] neg_ang;
        if (it.func == FUNC_LOAD)
        begin
            cam_face_x  = longint'(it.load_dir_x);
            cam_face_y  = longint'(it.load_dir_y);
            cam_plane_x = longint'(it.load_plane_x);
            cam_plane_y = longint'(it.load_plane_y);
        end
        else
        begin
            // The rate is 17 bits wide and is not saturated.
            prod = longint'(it.frame_period)
                 * (longint'(base_rate_shadow) + longint'(it.turn_offset));
            ang = 16'((prod + 64'sd4096) >>> 13);
            neg_ang = ~ang + 16'd1;
            if (it.turn_left)
            begin
                turn_vector(cam_face_x, cam_face_y, ang);
                turn_vector(cam_plane_x, cam_plane_y, ang);
            end
            if (it.turn_right)
            begin
                turn_vector(cam_face_x, cam_face_y, neg_ang);
                turn_vector(cam_plane_x, cam_plane_y, neg_ang);
            end
        end
        res.dir_x   = VW'(cam_face_x);
        res.dir_y   = VW'(cam_face_y);
        res.plane_x = VW'(cam_plane_x);
        res.plane_y = VW'(cam_plane_y);
        return res;
    endfunction

    // Unused fields get random values, since the block must ignore them.
    function automatic cam_item_t make_tick(input bit [15:0] ft, input bit [15:0] offset,
                                            input bit turn_l, input bit turn_r);
        cam_item_t it;
        it.func         = FUNC_TICK;
        it.frame_period = ft;
        it.turn_offset  = offset;
        it.turn_left    = turn_l;
        it.turn_right   = turn_r;
        it.load_dir_x   = VW'($urandom);
        it.load_dir_y   = VW'($urandom);
        it.load_plane_x = VW'($urandom);
        it.load_plane_y = VW'($urandom);
        return it;
    endfunction

    function automatic cam_item_t make_load(input bit [15:0] dx, input bit [15:0] dy,
                                            input bit [15:0] px, input bit [15:0] py);
        cam_item_t it;
        it.func         = FUNC_LOAD;
        it.frame_period = 16'($urandom);
        it.turn_offset  = 16'($urandom);
        it.turn_left    = 1'($urandom);
        it.turn_right   = 1'($urandom);
        it.load_dir_x   = dx;
        it.load_dir_y   = dy;
        it.load_plane_x = px;
        it.load_plane_y = py;
        return it;
    endfunction

    function automatic bit [15:0] random_component();
        if ($urandom_range(0, 2) == 0)
            return 16'($urandom);
        return 16'($urandom_range(0, 32768) - 16384);
    endfunction

    function automatic cam_item_t random_item();
        bit [15:0] ft;
        bit [15:0] offset;
        if ($urandom_range(0, 4) == 0)
            return make_load(random_component(), random_component(),
                             random_component(), random_component());
        // Mostly realistic frame periods and mouse offsets, sometimes anything.
        ft     = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 4000));
        offset = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 8192));
        return make_tick(ft, offset, 1'($urandom), 1'($urandom));
    endfunction

    task automatic send_item(input cam_item_t it);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 4);
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.func         <= it.func;
        in_ch.frame_period <= it.frame_period;
        in_ch.turn_offset  <= it.turn_offset;
        in_ch.turn_left    <= it.turn_left;
        in_ch.turn_right   <= it.turn_right;
        in_ch.load_dir_x   <= it.load_dir_x;
        in_ch.load_dir_y   <= it.load_dir_y;
        in_ch.load_plane_x <= it.load_plane_x;
        in_ch.load_plane_y <= it.load_plane_y;
        do
            @(posedge clk);
        while (!in_ch.ready);
        expected_vectors.push_back(predict_vectors(it));
    endtask

    task automatic drain_pipeline();
        in_ch.valid <= 1'b0;
        while (expected_vectors.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_base_rate(input bit [15:0] value);
        drain_pipeline();
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        base_rate_shadow = value;
    endtask

    task automatic test_reset_values();
        send_item(make_tick(16'd1092, 16'd0, 1'b0, 1'b0));
    endtask

    // With a total rate of 8192 the binary angle equals the frame period.
    task automatic test_turn_angles();
        send_item(make_tick(16'd0, 16'd0, 1'b1, 1'b0));
        send_item(make_tick(16'd0, 16'd0, 1'b0, 1'b1));
        send_item(make_tick(16'd1, 16'd7680, 1'b1, 1'b0));
        send_item(make_tick(16'd16384, 16'd7680, 1'b1, 1'b0));
        send_item(make_tick(16'd16385, 16'd7680, 1'b1, 1'b0));
        send_item(make_tick(16'd32768, 16'd7680, 1'b1, 1'b0));
        send_item(make_tick(16'd49152, 16'd7680, 1'b0, 1'b1));
        send_item(make_tick(16'd32767, 16'd7680, 1'b0, 1'b1));
        send_item(make_tick(16'd65535, 16'd7680, 1'b1, 1'b1));
        send_item(make_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
    endtask

    task automatic test_load_extremes();
        send_item(make_load(16'h7FFF, 16'h7FFF, 16'h8000, 16'h8000));
        send_item(make_tick(16'd8192, 16'd7680, 1'b1, 1'b0));
        send_item(make_load(16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000));
        send_item(make_tick(16'hFFFF, 16'hFFFF, 1'b0, 1'b0));
        send_item(make_load(16'hC000, 16'h0000, 16'h0000, 16'd10813));
    endtask

    task automatic test_rate_settings();
        write_base_rate(16'd0);
        send_item(make_tick(16'hFFFF, 16'd0, 1'b1, 1'b0));
        write_base_rate(16'hFFFF);
        send_item(make_tick(16'hFFFF, 16'hFFFF, 1'b1, 1'b1));
        send_item(make_tick(16'd12345, 16'd0, 1'b1, 1'b0));
        write_base_rate(16'd512);
        send_item(make_tick(16'd1092, 16'd300, 1'b0, 1'b1));
    endtask

    // The receiver stops for a long stretch so that the block fills and
    // stalls its input, then the sender waits for every result.
    task automatic test_output_backpressure();
        drain_pipeline();
        rx_hold_req = 300;
        for (int n = 0; n < 12; n++)
            send_item(random_item());
        drain_pipeline();
    endtask

    task automatic test_random_traffic();
        for (int phase = 0; phase < 5; phase++)
        begin
            case (phase)
                0: write_base_rate(16'd512);
                1: write_base_rate(16'($urandom));
                2: write_base_rate(16'd0);
                3: write_base_rate(16'hFFFF);
                default: write_base_rate(16'($urandom_range(256, 4096)));
            endcase
            no_idle = (phase == 1);
            for (int n = 0; n < 300; n++)
            begin
                if (n % 100 == 99)
                    drain_pipeline();
                send_item(random_item());
            end
        end
        no_idle = 1'b0;
    endtask

    // Receiver side: random stalls per transaction, plus a requested hold-off.
    initial
    begin
        int stall;
        int hold_len;
        out_ch.ready = 1'b0;
        @(posedge rst_n);
        @(posedge clk);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                hold_len    = rx_hold_req;
                rx_hold_req = 0;
                out_ch.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            stall = no_idle ? 0 : $urandom_range(0, 4);
            if (stall > 0)
            begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            out_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_ch.valid && out_ch.ready));
        end
    end

    task automatic check_field(input string name, input logic signed [VW-1:0] want,
                               input logic signed [VW-1:0] got);
        if (got !== want)
        begin
            mismatch_count++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    always @(posedge clk)
    begin
        cam_vec_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (expected_vectors.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected transaction, expected none, actual (%0d, %0d, %0d, %0d)",
                         $time, out_ch.dir_x, out_ch.dir_y, out_ch.plane_x, out_ch.plane_y);
            end
            else
            begin
                want = expected_vectors.pop_front();
                check_field("dir_x", want.dir_x, out_ch.dir_x);
                check_field("dir_y", want.dir_y, out_ch.dir_y);
                check_field("plane_x", want.plane_x, out_ch.plane_x);
                check_field("plane_y", want.plane_y, out_ch.plane_y);
            end
        end
    end

    initial
    begin
        #(8_000_000);
        $display("Some tests failed");
        $finish;
    end

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        in_ch.valid        = 1'b0;
        in_ch.func         = FUNC_TICK;
        in_ch.frame_period = '0;
        in_ch.turn_offset  = '0;
        in_ch.turn_left    = 1'b0;
        in_ch.turn_right   = 1'b0;
        in_ch.load_dir_x   = '0;
        in_ch.load_dir_y   = '0;
        in_ch.load_plane_x = '0;
        in_ch.load_plane_y = '0;
        mismatch_count     = 0;
        no_idle            = 1'b0;
        rx_hold_req        = 0;
        base_rate_shadow   = 16'd512;
        cam_face_x         = FACE_X_RESET;
        cam_face_y         = 0;
        cam_plane_x        = 0;
        cam_plane_y        = PLANE_Y_RESET;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_values();
        test_turn_angles();
        test_load_extremes();
        test_rate_settings();
        test_output_backpressure();
        test_random_traffic();

        drain_pipeline();
        repeat (100) @(posedge clk);
        if (mismatch_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
